### sv/alkd_pkg.sv
// Package for the analog ladder keypad decoder.
// Holds widths, button and command codes, register indexes and the event type.
// No dependencies.
package alkd_pkg;

	localparam int ADC_BITS    = 10;
	localparam int NUM_BUTTONS = 6;
	localparam int NUM_REGS    = 7;
	localparam int BTN_BITS    = 3;
	localparam int REG_BITS    = 3;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

	typedef logic [ADC_BITS-1:0] level_t;
	typedef logic [BTN_BITS-1:0] button_t;
	typedef logic [REG_BITS-1:0] reg_idx_t;

	localparam button_t BTN_NONE = button_t'(NUM_BUTTONS);

	localparam logic CMD_CLASSIFY = 1'b0;
	localparam logic CMD_LEARN    = 1'b1;

	localparam logic EVT_RELEASE = 1'b0;
	localparam logic EVT_PRESS   = 1'b1;

	localparam reg_idx_t REG_IDLE_LEVEL = reg_idx_t'(0);
	localparam reg_idx_t REG_LAST_LEVEL = reg_idx_t'(NUM_REGS - 1);

	localparam level_t IDLE_RESET = level_t'(0);
	localparam level_t LEVEL_RESET [NUM_BUTTONS] = '{
		level_t'(170), level_t'(340), level_t'(510),
		level_t'(680), level_t'(850), level_t'(1023)
	};

	typedef struct packed {
		logic    kind;
		button_t button;
		logic    last;
	} event_t;

	typedef struct packed {
		logic [1:0] cnt;
		event_t     evt0;
		event_t     evt1;
		button_t    best;
	} class_res_t;

	function automatic level_t abs_diff(input level_t a, input level_t b);
		return (a >= b) ? level_t'(a - b) : level_t'(b - a);
	endfunction

endpackage

### sv/analog_ladder_keypad_decoder.sv
// Analog ladder keypad decoder top level: input register, classifier, event queue.
// Depends on alkd_pkg, alkd_level_regs, alkd_classify and alkd_evt_fifo.
//
// Each request carries one 10-bit ADC sample (classify) or a learn command.
// A sample is matched to the nearest of the idle level and six button levels
// (ties go to the earlier of idle, up, right, down, left, go, reset); a change of
// button gives a release event for the old one and then a press event for the new
// one. Requests are taken one per cycle while in_stall is low and sit in one input
// register; their events then enter a four-entry event queue, so each event passes
// through the input register and the queue before it appears. The output side moves
// one event per cycle while out_stall is low; a classify request waits in the input
// register until the queue has room for two events. Learn requests store the last
// classified sample and never produce events. Configuration writes are always ready;
// writing a button level register loads it, winning over a learn to the same button.
module analog_ladder_keypad_decoder (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  alkd_pkg::reg_idx_t         cfg_index,
	input  alkd_pkg::level_t           cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       cmd,
	input  alkd_pkg::level_t           adc_sample,
	input  alkd_pkg::button_t          learn_button,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       event_kind,
	output alkd_pkg::button_t          button_id,
	output logic                       last_of_run
);
	import alkd_pkg::*;

	logic       valid_s1;
	logic       cmd_s1;
	level_t     sample_s1;
	button_t    learn_s1;
	level_t     last_sample_q;
	button_t    held_q;
	level_t     idle_level;
	level_t     levels [NUM_BUTTONS];
	class_res_t res;
	logic       room2;
	logic       adv_s1;
	logic       do_class;
	logic       learn_we;
	logic [1:0] push_cnt;
	event_t     out_evt;

	assign cfg_ready = 1'b1;

	assign adv_s1   = (cmd_s1 == CMD_LEARN) || room2;
	assign in_stall = valid_s1 && !adv_s1;
	assign do_class = valid_s1 && cmd_s1 == CMD_CLASSIFY && room2;
	assign learn_we = valid_s1 && cmd_s1 == CMD_LEARN;
	assign push_cnt = do_class ? res.cnt : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1    <= cmd;
			sample_s1 <= adc_sample;
			learn_s1  <= learn_button;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sample_q <= '0;
			held_q        <= BTN_NONE;
		end else if (do_class) begin
			last_sample_q <= sample_s1;
			held_q        <= res.best;
		end
	end

	alkd_level_regs u_levels (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.learn_we     (learn_we),
		.learn_button (learn_s1),
		.learn_level  (last_sample_q),
		.idle_level   (idle_level),
		.levels       (levels)
	);

	alkd_classify u_classify (
		.sample     (sample_s1),
		.idle_level (idle_level),
		.levels     (levels),
		.held       (held_q),
		.res        (res)
	);

	alkd_evt_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.push0     (res.evt0),
		.push1     (res.evt1),
		.room2     (room2),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_evt   (out_evt)
	);

	assign event_kind  = out_evt.kind;
	assign button_id   = out_evt.button;
	assign last_of_run = out_evt.last;

endmodule

### sv/alkd_level_regs.sv
// Idle level register and button level table of the keypad decoder.
// Written by configuration requests and by learn items; depends on alkd_pkg.
module alkd_level_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  alkd_pkg::reg_idx_t        cfg_index,
	input  alkd_pkg::level_t          cfg_data,
	input  logic                      learn_we,
	input  alkd_pkg::button_t         learn_button,
	input  alkd_pkg::level_t          learn_level,
	output alkd_pkg::level_t          idle_level,
	output alkd_pkg::level_t          levels [alkd_pkg::NUM_BUTTONS]
);
	import alkd_pkg::*;

	level_t idle_q;
	level_t table_q [NUM_BUTTONS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q <= IDLE_RESET;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				table_q[i] <= LEVEL_RESET[i];
			end
		end else begin
			if (cfg_we && cfg_index == REG_IDLE_LEVEL) begin
				idle_q <= cfg_data;
			end
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				if (cfg_we && cfg_index == reg_idx_t'(i + 1)) begin
					table_q[i] <= cfg_data;
				end else if (learn_we && learn_button == button_t'(i)) begin
					table_q[i] <= learn_level;
				end
			end
		end
	end

	assign idle_level = idle_q;
	assign levels     = table_q;

endmodule

### sv/alkd_classify.sv
// Nearest-level classifier and event builder of the keypad decoder.
// Pure combinational logic; depends on alkd_pkg.
module alkd_classify (
	input  alkd_pkg::level_t          sample,
	input  alkd_pkg::level_t          idle_level,
	input  alkd_pkg::level_t          levels [alkd_pkg::NUM_BUTTONS],
	input  alkd_pkg::button_t         held,
	output alkd_pkg::class_res_t      res
);
	import alkd_pkg::*;

	level_t  best_d;
	level_t  d;
	button_t best;

	always_comb begin
		best   = BTN_NONE;
		best_d = abs_diff(sample, idle_level);
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			d = abs_diff(sample, levels[i]);
			if (d < best_d) begin
				best_d = d;
				best   = button_t'(i);
			end
		end
	end

	always_comb begin
		res      = '0;
		res.best = best;
		if (best != held) begin
			if (held != BTN_NONE) begin
				res.evt0 = '{kind: EVT_RELEASE, button: held, last: (best == BTN_NONE)};
				if (best != BTN_NONE) begin
					res.evt1 = '{kind: EVT_PRESS, button: best, last: 1'b1};
					res.cnt  = 2'd2;
				end else begin
					res.cnt = 2'd1;
				end
			end else begin
				res.evt0 = '{kind: EVT_PRESS, button: best, last: 1'b1};
				res.cnt  = 2'd1;
			end
		end
	end

endmodule

### sv/alkd_evt_fifo.sv
// Event queue of the keypad decoder: takes up to two events a cycle, gives one while out_stall is low.
// Depends on alkd_pkg.
module alkd_evt_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [1:0]           push_cnt,
	input  alkd_pkg::event_t     push0,
	input  alkd_pkg::event_t     push1,
	output logic                 room2,
	output logic                 out_valid,
	input  logic                 out_stall,
	output alkd_pkg::event_t     out_evt
);
	import alkd_pkg::*;

	event_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]     wr_ptr_q;
	logic [FIFO_AW-1:0]     rd_ptr_q;
	logic [FIFO_AW:0]       count_q;
	logic                   pop;
	logic [FIFO_AW-1:0]     wr_ptr1;

	assign pop       = out_valid && !out_stall;
	assign out_valid = count_q != '0;
	assign out_evt   = mem_q[rd_ptr_q];
	assign room2     = count_q <= (FIFO_AW + 1)'(FIFO_DEPTH - 2);
	assign wr_ptr1   = wr_ptr_q + FIFO_AW'(1);

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push0;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_ptr1] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push_cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			count_q <= count_q + (FIFO_AW + 1)'(push_cnt) - (FIFO_AW + 1)'(pop);
		end
	end

endmodule

### bench/tb_analog_ladder_keypad_decoder.sv
// Testbench for analog_ladder_keypad_decoder: random and directed keypad requests
// are checked event by event against an in-bench model of the level matcher.
// Depends on alkd_pkg and the decoder RTL.
module tb_analog_ladder_keypad_decoder;
	import alkd_pkg::*;

	localparam int LEVEL_MAX      = (1 << ADC_BITS) - 1;
	localparam int WATCHDOG_LIMIT = 1500;
	localparam int CHOKE_CYCLES   = 150;
	localparam int MAX_PRINTS     = 100;
	localparam reg_idx_t REG_UNUSED = reg_idx_t'(REG_LAST_LEVEL + 1);

	typedef enum logic [BTN_BITS-1:0] {
		KEY_UP, KEY_RIGHT, KEY_DOWN, KEY_LEFT, KEY_GO, KEY_RESET, KEY_NONE, KEY_SPARE
	} key_e;

	typedef struct {
		logic    cmd;
		level_t  sample;
		button_t learn_btn;
	} keypad_req_t;

	logic     clk;
	logic     arst_n       = 1'b0;
	logic     cfg_valid    = 1'b0;
	logic     cfg_ready;
	reg_idx_t cfg_index    = REG_IDLE_LEVEL;
	level_t   cfg_data     = '0;
	logic     in_valid     = 1'b0;
	logic     in_stall;
	logic     cmd          = CMD_CLASSIFY;
	level_t   adc_sample   = '0;
	button_t  learn_button = '0;
	logic     out_valid;
	logic     out_stall    = 1'b0;
	logic     event_kind;
	button_t  button_id;
	logic     last_of_run;

	analog_ladder_keypad_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.adc_sample   (adc_sample),
		.learn_button (learn_button),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_kind   (event_kind),
		.button_id    (button_id),
		.last_of_run  (last_of_run)
	);

	// matcher model state
	level_t  idle_lvl = IDLE_RESET;
	level_t  key_lvl [NUM_BUTTONS] = LEVEL_RESET;
	level_t  prev_sample = '0;
	button_t held_key = BTN_NONE;

	keypad_req_t request_q[$];
	event_t      expected_events[$];
	level_t      centers [NUM_REGS] = '{
		IDLE_RESET, LEVEL_RESET[0], LEVEL_RESET[1], LEVEL_RESET[2],
		LEVEL_RESET[3], LEVEL_RESET[4], LEVEL_RESET[5]
	};
	int          cur_target = 0;

	logic req_taken = 1'b0;
	logic evt_taken = 1'b0;
	logic cfg_taken = 1'b0;
	int   src_gap_max = 0;
	int   snk_gap_max = 0;
	int   gap_left = 0;
	int   stall_left = 0;
	int   choke_left = 0;
	bit   choke_request = 1'b0;
	bit   choke_done = 1'b0;
	int   quiet_cycles = 0;

	int items_queued = 0;
	int items_taken = 0;
	int learns_taken = 0;
	int cfg_writes = 0;
	int presses_seen = 0;
	int releases_seen = 0;
	int mismatches = 0;
	int settings_run = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < MAX_PRINTS)
			$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	function automatic int level_dist(input level_t a, input level_t b);
		int v;
		v = int'(a) - int'(b);
		return (v < 0) ? -v : v;
	endfunction

	task automatic apply_write(input reg_idx_t idx, input level_t val);
		if (idx == REG_IDLE_LEVEL)
			idle_lvl = val;
		else if (idx <= REG_LAST_LEVEL)
			key_lvl[idx - 1] = val;
	endtask

	task automatic apply_request(input logic c, input level_t s, input button_t b);
		button_t best;
		int      best_d;
		int      d;
		event_t  ev;
		if (c == CMD_LEARN) begin
			if (b < BTN_NONE) key_lvl[b] = prev_sample;
			return;
		end
		prev_sample = s;
		best = BTN_NONE;
		best_d = level_dist(s, idle_lvl);
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			d = level_dist(s, key_lvl[i]);
			if (d < best_d) begin
				best_d = d;
				best = button_t'(i);
			end
		end
		if (best != held_key) begin
			if (held_key != BTN_NONE) begin
				ev.kind = EVT_RELEASE;
				ev.button = held_key;
				ev.last = (best == BTN_NONE);
				expected_events.push_back(ev);
			end
			if (best != BTN_NONE) begin
				ev.kind = EVT_PRESS;
				ev.button = best;
				ev.last = 1'b1;
				expected_events.push_back(ev);
			end
			held_key = best;
		end
	endtask

	task automatic check_event();
		event_t want;
		if (expected_events.size() == 0) begin
			report_mismatch("event with none pending, button", button_id, BTN_NONE);
			return;
		end
		want = expected_events.pop_front();
		if (event_kind !== want.kind) report_mismatch("event_kind", event_kind, want.kind);
		if (button_id !== want.button) report_mismatch("button_id", button_id, want.button);
		if (last_of_run !== want.last) report_mismatch("last_of_run", last_of_run, want.last);
		if (want.kind == EVT_PRESS) presses_seen++;
		else releases_seen++;
	endtask

	// sample side: apply accepted writes, predict on accepted requests, check accepted events
	always @(posedge clk) begin
		req_taken <= in_valid && !in_stall;
		evt_taken <= out_valid && !out_stall;
		cfg_taken <= cfg_valid && cfg_ready;
		if (cfg_valid && cfg_ready) begin
			apply_write(cfg_index, cfg_data);
			cfg_writes++;
		end
		if (in_valid && !in_stall) begin
			apply_request(cmd, adc_sample, learn_button);
			items_taken++;
			if (cmd == CMD_LEARN) learns_taken++;
		end
		if (out_valid === 1'b1 && !out_stall) check_event();
	end

	always @(negedge clk) begin : request_driver
		keypad_req_t nxt;
		if (!in_valid || req_taken) begin
			if (req_taken) gap_left = $urandom_range(0, src_gap_max);
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (request_q.size() != 0) begin
				nxt = request_q.pop_front();
				in_valid <= 1'b1;
				cmd <= nxt.cmd;
				adc_sample <= nxt.sample;
				learn_button <= nxt.learn_btn;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (choke_request && !choke_done) begin
			choke_left = CHOKE_CYCLES;
			choke_done = 1'b1;
		end
		if (evt_taken) stall_left = $urandom_range(0, snk_gap_max);
		if (choke_left > 0) begin
			choke_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall) ||
		    (cfg_valid && cfg_ready === 1'b1))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", quiet_cycles);
			$display("FAILURE");
			$finish;
		end
	end

	task automatic write_reg(input reg_idx_t idx, input level_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_taken);
	endtask

	task automatic program_levels(input level_t idle, input level_t up, input level_t right,
			input level_t down, input level_t left, input level_t go, input level_t rst);
		level_t vals [NUM_REGS];
		vals[0] = idle;
		vals[1] = up;
		vals[2] = right;
		vals[3] = down;
		vals[4] = left;
		vals[5] = go;
		vals[6] = rst;
		for (int i = 0; i < NUM_REGS; i++) begin
			if (i == 3) write_reg(REG_UNUSED, level_t'($urandom));
			write_reg(reg_idx_t'(REG_IDLE_LEVEL + i), vals[i]);
			centers[i] = vals[i];
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic push_req(input logic c, input level_t s, input button_t b);
		keypad_req_t r;
		r.cmd = c;
		r.sample = s;
		r.learn_btn = b;
		request_q.push_back(r);
		items_queued++;
	endtask

	function automatic keypad_req_t random_req();
		keypad_req_t r;
		int          v;
		r.cmd = CMD_CLASSIFY;
		r.sample = level_t'($urandom);
		r.learn_btn = button_t'($urandom);
		if ($urandom_range(0, 2) == 0) cur_target = $urandom_range(0, NUM_REGS - 1);
		case ($urandom_range(0, 9))
			0: r.cmd = CMD_LEARN;
			1, 2: ;
			default: begin
				v = int'(centers[cur_target]) + int'($urandom_range(0, 40)) - 20;
				r.sample = level_t'((v < 0) ? 0 : ((v > LEVEL_MAX) ? LEVEL_MAX : v));
			end
		endcase
		return r;
	endfunction

	task automatic run_phase(input int n_rand, input int src_max, input int snk_max,
			input bit choke);
		@(posedge clk);
		src_gap_max = src_max;
		snk_gap_max = snk_max;
		for (int i = 0; i < n_rand; i++) begin
			request_q.push_back(random_req());
			items_queued++;
		end
		if (choke) choke_request = 1'b1;
		do @(negedge clk); while (items_taken != items_queued || expected_events.size() != 0);
		repeat (8) @(negedge clk);
		settings_run++;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		@(posedge clk);
		push_req(CMD_LEARN, level_t'($urandom), KEY_DOWN);
		push_req(CMD_LEARN, level_t'($urandom), KEY_NONE);
		push_req(CMD_LEARN, level_t'($urandom), KEY_SPARE);
		push_req(CMD_CLASSIFY, 0, KEY_UP);
		push_req(CMD_CLASSIFY, 170, KEY_SPARE);
		push_req(CMD_CLASSIFY, 172, KEY_UP);
		push_req(CMD_CLASSIFY, 340, KEY_UP);
		push_req(CMD_CLASSIFY, 510, KEY_UP);
		push_req(CMD_CLASSIFY, 850, KEY_UP);
		push_req(CMD_CLASSIFY, LEVEL_MAX, KEY_UP);
		push_req(CMD_CLASSIFY, 1020, KEY_UP);
		push_req(CMD_CLASSIFY, 0, KEY_UP);
		push_req(CMD_CLASSIFY, 85, KEY_UP);
		push_req(CMD_CLASSIFY, 255, KEY_UP);
		push_req(CMD_LEARN, 0, KEY_DOWN);
		push_req(CMD_CLASSIFY, 255, KEY_UP);
		push_req(CMD_CLASSIFY, 765, KEY_UP);
		push_req(CMD_LEARN, LEVEL_MAX, KEY_GO);
		push_req(CMD_CLASSIFY, 765, KEY_UP);
		push_req(CMD_CLASSIFY, 'h155, KEY_UP);
		push_req(CMD_CLASSIFY, 'h2AA, KEY_UP);
		push_req(CMD_CLASSIFY, 1, KEY_UP);
		push_req(CMD_LEARN, 0, KEY_RESET);
		push_req(CMD_CLASSIFY, 1, KEY_UP);
		run_phase(250, 13, 13, 1'b0);

		program_levels(990, 0, 145, 329, 505, 741, LEVEL_MAX);
		run_phase(300, 0, 0, 1'b1);

		program_levels(LEVEL_MAX, 0, 0, 0, 0, 0, 0);
		run_phase(200, 13, 0, 1'b0);

		program_levels(0, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX);
		run_phase(200, 0, 13, 1'b0);

		program_levels(512, 512, 512, 512, 512, 512, 512);
		run_phase(150, 6, 6, 1'b0);

		program_levels(level_t'($urandom), level_t'($urandom), level_t'($urandom),
			level_t'($urandom), level_t'($urandom), level_t'($urandom), level_t'($urandom));
		run_phase(300, 13, 13, 1'b0);

		program_levels(IDLE_RESET, LEVEL_RESET[0], LEVEL_RESET[1], LEVEL_RESET[2],
			LEVEL_RESET[3], LEVEL_RESET[4], LEVEL_RESET[5]);
		run_phase(300, 3, 9, 1'b0);

		repeat (20) @(negedge clk);
		$display("covered %0d keypad requests (%0d learns) over %0d level settings, %0d writes",
			items_taken, learns_taken, settings_run, cfg_writes);
		$display("checked %0d presses and %0d releases, %0d mismatches",
			presses_seen, releases_seen, mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
